// ----- rtl/rif_pkg.sv -----
package rif_pkg;

    // integer square root: 64-bit radicand, one root bit per stage
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int COORD_W = 32;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_STRENGTH = 3'd3,
        REG_RADIUS   = 3'd4
    } cfg_reg_t;

endpackage

// ----- rtl/rif_sqrt.sv -----
module rif_sqrt
    import rif_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [SUM_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    localparam int NST = ROOT_W;

    logic [ROOT_W:0]     rem_reg  [NST-1];
    logic [SUM_W-1:0]    sh_reg   [NST-1];
    logic [ROOT_W-1:0]   root_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [ROOT_W:0]   rem_in;
        logic [SUM_W-1:0]  sh_in;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W+2:0] rem_t;
        logic [ROOT_W+2:0] trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign sh_in   = radicand;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign sh_in   = sh_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_t = {rem_in, sh_in[SUM_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (rem_t >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
            end
        end

        if (k < NST-1) begin : g_carry
            logic [ROOT_W+2:0] rem_n;
            assign rem_n = ge ? (rem_t - trial) : rem_t;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_n[ROOT_W:0];
                    sh_reg[k]  <= {sh_in[SUM_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[NST-1];

endmodule

// ----- rtl/rif_div.sv -----
module rif_div #(
    parameter int QB = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [31:0]   num,
    input  logic [31:0]   den,
    output logic [QB-1:0] quo
);

    // num <= den, so quo = (num << (QB-1)) / den fits QB bits
    logic [31:0]   rem_reg [QB-1];
    logic [31:0]   den_reg [QB-1];
    logic [QB-1:0] q_reg   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [32:0]   shifted;
        logic [31:0]   den_in;
        logic [QB-1:0] q_in;
        logic [32:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign shifted = {1'b0, num};
            assign den_in  = den;
            assign q_in    = '0;
        end else begin : g_rest
            assign shifted = {rem_reg[k-1], 1'b0};
            assign den_in  = den_reg[k-1];
            assign q_in    = q_reg[k-1];
        end

        assign ge   = (shifted >= {1'b0, den_in});
        assign diff = shifted - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k] <= {q_in[QB-2:0], ge};
            end
        end

        if (k < QB-1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[31:0] : shifted[31:0];
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = q_reg[QB-1];

endmodule

// ----- rtl/radial_impulse_falloff.sv -----
// Radial blast impulse on a stream of 3-D points, all values fixed point
// with FRAC_BITS fraction bits. One point is taken per cycle while the
// result side takes results; a stall holds the whole pipeline. Four
// front stages form the offset, its squares and the range test, a
// 32-stage square root finds the distance, FRAC_BITS+1 division stages
// give the falloff and unit offset, and three multiply stages scale the
// result. A point outside the radius gets zero impulse and in_range low;
// a point at the center gets zero impulse and in_range high. Write
// configuration only while no transfer is in flight.
module radial_impulse_falloff
    import rif_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_point_x,
    input  logic signed [31:0]    s_point_y,
    input  logic signed [31:0]    s_point_z,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_impulse_x,
    output logic signed [31:0]    m_impulse_y,
    output logic signed [31:0]    m_impulse_z,
    output logic                  m_in_range
);

    localparam int QB = FRAC_BITS + 1;

    typedef struct packed {
        logic                         vld;
        logic                         in_range;
        logic                         zero;
        logic [2:0]                   neg;
        logic [2:0][COORD_W-1:0]      a;
    } sb_t;

    // configuration
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [31:0]        strength_reg, radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg       <= '0;
            cy_reg       <= '0;
            cz_reg       <= '0;
            strength_reg <= 32'(1) << FRAC_BITS;
            radius_reg   <= 32'(1) << FRAC_BITS;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CENTER_X: cx_reg       <= cfg_wdata;
                REG_CENTER_Y: cy_reg       <= cfg_wdata;
                REG_CENTER_Z: cz_reg       <= cfg_wdata;
                REG_STRENGTH: strength_reg <= cfg_wdata;
                REG_RADIUS:   radius_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && aresetn;

    // stage 1: offset from center
    logic               v1_reg;
    logic signed [32:0] d1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0] <= 33'(s_point_x) - 33'(cx_reg);
            d1_reg[1] <= 33'(s_point_y) - 33'(cy_reg);
            d1_reg[2] <= 33'(s_point_z) - 33'(cz_reg);
        end
    end

    // stage 2: magnitudes and coarse range test
    logic              v2_reg, big2_reg;
    logic [2:0]        neg2_reg;
    logic [31:0]       a2_reg [3];
    logic [31:0]       a2_next [3];
    logic              big2_next;

    always_comb begin
        big2_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a2_next[i] = d1_reg[i][32] ? 32'(-d1_reg[i]) : d1_reg[i][31:0];
            if (a2_next[i] > radius_reg) begin
                big2_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big2_reg <= big2_next;
            for (int i = 0; i < 3; i++) begin
                a2_reg[i]   <= a2_next[i];
                neg2_reg[i] <= d1_reg[i][32];
            end
        end
    end

    // stage 3: squares
    logic              v3_reg, big3_reg;
    logic [2:0]        neg3_reg;
    logic [31:0]       a3_reg [3];
    logic [63:0]       sq3_reg [3];
    logic [63:0]       rr3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big3_reg <= big2_reg;
            neg3_reg <= neg2_reg;
            rr3_reg  <= 64'(radius_reg) * 64'(radius_reg);
            for (int i = 0; i < 3; i++) begin
                a3_reg[i]  <= a2_reg[i];
                sq3_reg[i] <= 64'(a2_reg[i]) * 64'(a2_reg[i]);
            end
        end
    end

    // stage 4: sum of squares and exact range test
    logic [65:0] sum4;
    sb_t         sb4_reg;
    logic [63:0] s4_reg;
    sb_t         sb4_next;

    always_comb begin
        sum4 = 66'(sq3_reg[0]) + 66'(sq3_reg[1]) + 66'(sq3_reg[2]);
        sb4_next.vld      = v3_reg;
        sb4_next.in_range = !big3_reg && (sum4 <= 66'(rr3_reg));
        sb4_next.zero     = (sum4 == '0);
        sb4_next.neg      = neg3_reg;
        for (int i = 0; i < 3; i++) begin
            sb4_next.a[i] = a3_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb4_reg <= '0;
        end else if (en) begin
            sb4_reg <= sb4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg <= sum4[63:0];
        end
    end

    // distance
    logic [ROOT_W-1:0] distance;
    sb_t               sb_sq_reg [ROOT_W];

    rif_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (s4_reg),
        .root     (distance)
    );

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sb_sq
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sb_sq_reg[k] <= '0;
            end else if (en) begin
                sb_sq_reg[k] <= (k == 0) ? sb4_reg : sb_sq_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // falloff and unit offset
    sb_t          sb_d;
    logic [QB-1:0] f_q;
    logic [QB-1:0] u_q [3];
    sb_t          sb_dv_reg [QB];

    assign sb_d = sb_sq_reg[ROOT_W-1];

    rif_div #(.QB(QB)) u_div_f (
        .aclk (aclk),
        .en   (en),
        .num  (radius_reg - distance),
        .den  (radius_reg),
        .quo  (f_q)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div_u
        rif_div #(.QB(QB)) u_div_u (
            .aclk (aclk),
            .en   (en),
            .num  (sb_d.a[i]),
            .den  (distance),
            .quo  (u_q[i])
        );
    end

    for (genvar k = 0; k < QB; k++) begin : g_sb_dv
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sb_dv_reg[k] <= '0;
            end else if (en) begin
                sb_dv_reg[k] <= (k == 0) ? sb_d : sb_dv_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // multiply stage 1: squared falloff
    sb_t           sb_m1_reg;
    logic [QB-1:0] f2_reg;
    logic [QB-1:0] u_m1_reg [3];
    logic [2*QB-1:0] ff_prod;

    assign ff_prod = f_q * f_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_m1_reg <= '0;
        end else if (en) begin
            sb_m1_reg <= sb_dv_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_reg <= ff_prod[FRAC_BITS +: QB];
            for (int i = 0; i < 3; i++) begin
                u_m1_reg[i] <= u_q[i];
            end
        end
    end

    // multiply stage 2: unit offset times falloff
    sb_t             sb_m2_reg;
    logic [QB-1:0]   m1_reg [3];
    logic [2*QB-1:0] uf_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            uf_prod[i] = u_m1_reg[i] * f2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_m2_reg <= '0;
        end else if (en) begin
            sb_m2_reg <= sb_m1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m1_reg[i] <= uf_prod[i][FRAC_BITS +: QB];
            end
        end
    end

    // multiply stage 3: strength, scale by 1/8, sign, output register
    logic [QB+31:0]     ms_prod [3];
    logic signed [31:0] imp_next [3];
    logic               in_range_reg;
    logic signed [31:0] imp_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ms_prod[i]  = (QB+32)'(m1_reg[i]) * (QB+32)'(strength_reg);
            imp_next[i] = {3'b000, ms_prod[i][FRAC_BITS+3 +: 29]};
            if (sb_m2_reg.neg[i]) begin
                imp_next[i] = -imp_next[i];
            end
            // drop the impulse outside the radius and at the center
            if (!sb_m2_reg.in_range || sb_m2_reg.zero) begin
                imp_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sb_m2_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_range_reg <= sb_m2_reg.in_range;
            for (int i = 0; i < 3; i++) begin
                imp_reg[i] <= imp_next[i];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_impulse_x = imp_reg[0];
    assign m_impulse_y = imp_reg[1];
    assign m_impulse_z = imp_reg[2];
    assign m_in_range  = in_range_reg;

    logic [31:0] abs_x;
    assign abs_x = m_impulse_x[31] ? 32'(-m_impulse_x) : m_impulse_x;

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_impulse_x == 0 && m_impulse_y == 0 && m_impulse_z == 0)
        else $error("impulse nonzero outside radius");

    a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> abs_x <= {3'b000, strength_reg[31:3]})
        else $error("impulse magnitude above strength/8");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sb_m2_reg) && $stable(sb_dv_reg[0]))
        else $error("pipeline moved during stall");

endmodule

// ----- verif/tb_radial_impulse_falloff.sv -----
module tb_radial_impulse_falloff;
    import rif_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               in_range;
    } impulse_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [31:0]    s_point_x;
    logic signed [31:0]    s_point_y;
    logic signed [31:0]    s_point_z;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [31:0]    m_impulse_x;
    logic signed [31:0]    m_impulse_y;
    logic signed [31:0]    m_impulse_z;
    logic                  m_in_range;

    // blast configuration as seen by the predictor
    logic signed [31:0] blast_cx, blast_cy, blast_cz;
    logic [31:0]        blast_strength, blast_radius;

    impulse_t impulse_queue[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       error_count;
    int       result_count;
    int       in_range_count;
    int       cycle_count;

    radial_impulse_falloff #(.FRAC_BITS(FRAC_BITS)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_impulse_x (m_impulse_x),
        .m_impulse_y (m_impulse_y),
        .m_impulse_z (m_impulse_z),
        .m_in_range  (m_in_range)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic impulse_t predict_impulse(logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] pz);
        longint          d [3];
        longint unsigned a [3];
        longint unsigned r, root, f, f2, u, m;
        logic [65:0]     sum, trial;
        logic            ok;
        logic [31:0]     comp [3];
        impulse_t        res;
        d[0] = longint'(px) - longint'(blast_cx);
        d[1] = longint'(py) - longint'(blast_cy);
        d[2] = longint'(pz) - longint'(blast_cz);
        r  = longint'(blast_radius);
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            a[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            if (a[i] > r)
                ok = 1'b0;
            comp[i] = '0;
        end
        sum = '0;
        if (ok) begin
            for (int i = 0; i < 3; i++)
                sum = sum + 66'(a[i]) * 66'(a[i]);
            if (sum[65:64] != 2'b00 || sum > 66'(r) * 66'(r))
                ok = 1'b0;
        end
        if (ok && sum != 0) begin
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = 66'(root | (64'd1 << b));
                if (trial * trial <= sum)
                    root = root | (64'd1 << b);
            end
            f  = ((r - root) << FRAC_BITS) / r;
            f2 = (f * f) >> FRAC_BITS;
            for (int i = 0; i < 3; i++) begin
                u = (a[i] << FRAC_BITS) / root;
                m = (u * f2) >> FRAC_BITS;
                m = (m * longint'(blast_strength)) >> FRAC_BITS;
                m = m >> 3;
                comp[i] = (d[i] < 0) ? 32'(0 - m) : 32'(m);
            end
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.in_range = ok;
        return res;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // predict on each input transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            impulse_queue = {impulse_queue,
                             predict_impulse(s_point_x, s_point_y, s_point_z)};
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result transfer against the oldest prediction
    always @(posedge aclk) begin
        impulse_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_impulse_x, m_impulse_y, m_impulse_z, m_in_range};
            if (impulse_queue.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result x=%h y=%h z=%h in_range=%b", $time,
                         got.x, got.y, got.z, got.in_range);
            end else begin
                want = impulse_queue.pop_front();
                result_count++;
                if (want.in_range)
                    in_range_count++;
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected x=%h y=%h z=%h in_range=%b",
                             $time, want.x, want.y, want.z, want.in_range);
                    $display("%0t:          actual   x=%h y=%h z=%h in_range=%b",
                             $time, got.x, got.y, got.z, got.in_range);
                end
            end
        end
    end

    task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_CENTER_X: blast_cx       = data;
            REG_CENTER_Y: blast_cy       = data;
            REG_CENTER_Z: blast_cz       = data;
            REG_STRENGTH: blast_strength = data;
            REG_RADIUS:   blast_radius   = data;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_blast(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] strength, logic [31:0] radius);
        write_cfg(REG_CENTER_X, cx);
        write_cfg(REG_CENTER_Y, cy);
        write_cfg(REG_CENTER_Z, cz);
        write_cfg(REG_STRENGTH, strength);
        write_cfg(REG_RADIUS, radius);
    endtask

    task automatic wait_drained();
        while (impulse_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        forever begin
            @(negedge aclk);
            if (s_ready) begin
                @(posedge aclk);
                break;
            end
            @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly points inside or just around the sphere, some anywhere
    function automatic logic [31:0] near_coord(logic [31:0] c);
        longint unsigned lim;
        longint          off;
        lim = (longint'(blast_radius) + longint'(blast_radius) / 4) >> $urandom_range(2);
        off = longint'({$urandom, $urandom} % (2 * lim + 1)) - longint'(lim);
        return 32'(longint'($signed(c)) + off);
    endfunction

    task automatic send_random_point();
        int pick;
        pick = $urandom_range(99);
        if (pick < 72)
            send_point(near_coord(blast_cx), near_coord(blast_cy), near_coord(blast_cz));
        else if (pick < 87)
            send_point($urandom, $urandom, $urandom);
        else if (pick < 92)
            send_point(blast_cx, blast_cy, blast_cz);
        else
            send_point(blast_cx + blast_radius, blast_cy, near_coord(blast_cz));
    endtask

    function automatic logic [31:0] random_radius();
        case ($urandom_range(3))
            0: return $urandom_range(1, 64);
            1: return $urandom_range(1, 32'h0010_0000);
            2: return $urandom_range(1, 32'h0400_0000);
            default: return ($urandom == 0) ? 32'd1 : $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // reset configuration: unit radius and strength at the origin
        send_point(0, 0, 0);
        send_point(32'h0001_0000, 0, 0);
        send_point(0, 32'hFFFF_0000, 0);
        send_point(0, 0, 32'h0001_0001);
        send_point(1, 0, 0);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_B505, 32'h0000_B505, 0);
        stop_sending();
        wait_drained();
        // write to an unlisted index must not disturb the radius
        write_cfg(REG_UNUSED, 32'h0000_0001);
        send_point(32'h0000_C000, 0, 0);
        stop_sending();
        wait_drained();
        // widest radius and strength: sums of squares near 64 bits
        set_blast(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 0);
        stop_sending();
        wait_drained();
        set_blast(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        stop_sending();
        wait_drained();
        set_blast(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        stop_sending();
        wait_drained();
        // smallest radius: only the center and its immediate neighbors
        set_blast(32'h0000_1234, 32'hFFFF_0000, 32'h8000_0000, 32'h0008_0000, 1);
        send_point(32'h0000_1234, 32'hFFFF_0000, 32'h8000_0000);
        send_point(32'h0000_1235, 32'hFFFF_0000, 32'h8000_0000);
        send_point(32'h0000_1235, 32'hFFFF_0001, 32'h8000_0000);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_blast($urandom, $urandom, $urandom, $urandom, random_radius());
        for (int n = 0; n < count; n++) begin
            if (n % 120 == 119) begin
                stop_sending();
                wait_drained();
                set_blast($urandom, $urandom, $urandom, $urandom, random_radius());
            end
            send_random_point();
        end
        stop_sending();
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 20;
        recv_stall_pct = 30;
        for (int n = 0; n < 40; n++)
            send_random_point();
        // hold off until the pipeline is empty, then resume
        s_valid <= 1'b0;
        while (impulse_queue.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
        for (int n = 0; n < 40; n++)
            send_random_point();
        stop_sending();
        wait_drained();
    endtask

    initial begin
        int waited;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_point_x      = '0;
        s_point_y      = '0;
        s_point_z      = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        result_count   = 0;
        in_range_count = 0;
        cycle_count    = 0;
        blast_cx       = '0;
        blast_cy       = '0;
        blast_cz       = '0;
        blast_strength = 32'h0001_0000;
        blast_radius   = 32'h0001_0000;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(0, 0, 460);
        test_random_phase(65, 0, 460);
        test_random_phase(0, 65, 460);
        test_random_phase(13, 13, 460);
        test_drain_pause();

        waited = 0;
        while (impulse_queue.size() != 0 && waited < 10000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (impulse_queue.size() != 0) begin
            error_count++;
            $display("%0t: %0d predicted results never arrived", $time,
                     impulse_queue.size());
        end
        $display("covered %0d results (%0d inside the blast radius) over several blast",
                 result_count, in_range_count);
        $display("settings and idle/stall mixes, %0d errors", error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- radial_impulse_falloff.f -----
rtl/rif_pkg.sv
rtl/rif_sqrt.sv
rtl/rif_div.sv
rtl/radial_impulse_falloff.sv
verif/tb_radial_impulse_falloff.sv
